[rtl/core/pbba_pkg.sv]
// Package for the paged bitmap buddy allocator: payload structs, job and
// status codes, fixed geometry constants and the bitmap helper functions.
// No dependencies.
package pbba_pkg;

    localparam int PAGES          = 256;
    localparam int PAGE_AW        = 8;
    localparam int LEVEL_COUNT    = 7;
    localparam int HEADER_BYTES   = 24;
    localparam int MIN_BLOCK_BITS = 10;
    localparam int PAGE_BITS      = 16;

    localparam logic [2:0] ST_ALLOCATED = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [23:0] request_bytes;
        logic [23:0] free_offset;
        logic [23:0] free_capacity;
    } t_request;

    typedef struct packed {
        logic [23:0] alloc_offset;
        logic [16:0] block_capacity;
        logic [2:0]  status;
    } t_result;

    typedef enum logic [1:0] {
        JOB_ALLOC,
        JOB_FREE,
        JOB_REPLY
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [2:0]  status;
        logic [2:0]  level;
        logic [7:0]  page;
        logic [5:0]  blk;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } t_back_state;

    function automatic logic [63:0] group_mask(input logic [2:0] lv);
        logic [63:0] m;
        unique case (lv)
            3'd0:    m = 64'h0000000000000001;
            3'd1:    m = 64'h0000000100000001;
            3'd2:    m = 64'h0001000100010001;
            3'd3:    m = 64'h0101010101010101;
            3'd4:    m = 64'h1111111111111111;
            3'd5:    m = 64'h5555555555555555;
            default: m = 64'hFFFFFFFFFFFFFFFF;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] block_pattern(input logic [2:0] lv);
        logic [63:0] m;
        unique case (lv)
            3'd0:    m = 64'hFFFFFFFFFFFFFFFF;
            3'd1:    m = 64'h00000000FFFFFFFF;
            3'd2:    m = 64'h000000000000FFFF;
            3'd3:    m = 64'h00000000000000FF;
            3'd4:    m = 64'h000000000000000F;
            3'd5:    m = 64'h0000000000000003;
            default: m = 64'h0000000000000001;
        endcase
        return m;
    endfunction

    // Collapse the map so that bit 0 of each aligned group says "any busy".
    function automatic logic [63:0] fold_map(input logic [63:0] m, input logic [2:0] lv);
        logic [63:0] f;
        f = m;
        for (int j = LEVEL_COUNT - 1; j > 0; j--) begin
            if (j > int'(lv)) begin
                f = ((f >> (1 << (LEVEL_COUNT - 1 - j))) | f) & group_mask(3'(j - 1));
            end
        end
        return f;
    endfunction

    function automatic logic [5:0] lowest_set(input logic [63:0] v);
        logic [5:0] n;
        n = 6'd63;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

endpackage

[rtl/core/pbba_front.sv]
// Front end of the allocator: classifies a request into a job for the back end.
// Depends on pbba_pkg.
module pbba_front (
    input  pbba_pkg::t_request i_request,
    output pbba_pkg::t_job     o_job
);
    import pbba_pkg::*;

    logic [24:0] need;
    logic [23:0] base;
    logic        bad_free;
    logic [23:0] cap;

    always_comb begin
        need     = {1'b0, i_request.request_bytes} + 25'(HEADER_BYTES);
        cap      = i_request.free_capacity;
        base     = i_request.free_offset - 24'(HEADER_BYTES);
        bad_free = (i_request.free_offset < 24'(HEADER_BYTES)) || (cap < 24'd1024)
                   || (cap > 24'd65536) || ((cap & (cap - 24'd1)) != 24'd0);
        o_job        = '0;
        o_job.kind   = JOB_REPLY;
        o_job.page   = base[23:16];
        o_job.blk    = base[15:10];
        if (i_request.cmd == CMD_ALLOC) begin
            if (need > 25'd65536) begin
                o_job.status = ST_TOO_LARGE;
            end else begin
                o_job.kind = JOB_ALLOC;
                if (need <= 25'd1024)       o_job.level = 3'd6;
                else if (need <= 25'd2048)  o_job.level = 3'd5;
                else if (need <= 25'd4096)  o_job.level = 3'd4;
                else if (need <= 25'd8192)  o_job.level = 3'd3;
                else if (need <= 25'd16384) o_job.level = 3'd2;
                else if (need <= 25'd32768) o_job.level = 3'd1;
                else                        o_job.level = 3'd0;
            end
        end else begin
            if (bad_free) begin
                o_job.status = ST_IGNORED;
            end else begin
                o_job.kind = JOB_FREE;
                if (cap[16])      o_job.level = 3'd0;
                else if (cap[15]) o_job.level = 3'd1;
                else if (cap[14]) o_job.level = 3'd2;
                else if (cap[13]) o_job.level = 3'd3;
                else if (cap[12]) o_job.level = 3'd4;
                else if (cap[11]) o_job.level = 3'd5;
                else              o_job.level = 3'd6;
            end
        end
    end

endmodule

[rtl/core/pbba_queue.sv]
// Two-entry job queue between the allocator front and back ends.
// Depends on pbba_pkg.
module pbba_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbba_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output pbba_pkg::t_job o_job,
    input  logic           i_pop
);
    import pbba_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[rtl/core/pbba_back.sv]
// Back end of the allocator: page map store, level hints and the scan engine.
// Depends on pbba_pkg.
module pbba_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [8:0]        i_limit,
    input  logic              i_job_valid,
    input  pbba_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_result_valid,
    output pbba_pkg::t_result o_result
);
    import pbba_pkg::*;

    logic [63:0] r_mem [PAGES];
    logic [PAGES-1:0] r_written;
    logic [63:0] r_rd_data;
    logic        r_rd_written;

    logic [8:0]  r_hint [LEVEL_COUNT];
    t_back_state r_state, n_state;
    t_job        r_job, n_job;
    logic [7:0]  r_pg, n_pg;
    logic        r_scan, n_scan;
    logic [8:0]  r_start, n_start;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic        wr_en;
    logic [63:0] wr_data;
    logic        hint_en;
    logic [8:0]  hint_val;

    logic [63:0] cur_map, freeb;
    logic [5:0]  idx;
    logic [16:0] cap;
    logic        full;
    logic [8:0]  nxt_pg;
    logic [8:0]  hint_in;

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pg] <= wr_data;
        end
        r_rd_data    <= r_mem[r_pg];
        r_rd_written <= r_written[r_pg];
    end

    always_comb begin
        cur_map = r_rd_written ? r_rd_data : 64'd0;
        freeb   = ~fold_map(cur_map, r_job.level) & group_mask(r_job.level);
        idx     = lowest_set(freeb);
        cap     = 17'h10000 >> r_job.level;
        full    = ({1'b0, idx, 10'd0} + cap) == 17'h10000;
        nxt_pg  = {1'b0, r_pg} + 9'd1;
        hint_in = r_hint[i_job.level];
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_pg        = r_pg;
        n_scan      = r_scan;
        n_start     = r_start;
        n_out_valid = 1'b0;
        n_out       = r_out;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_data     = cur_map;
        hint_en     = 1'b0;
        hint_val    = r_hint[r_job.level];
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_out = '0;
                    unique case (i_job.kind)
                        JOB_ALLOC: begin
                            n_start = hint_in;
                            if (hint_in < i_limit) begin
                                n_pg    = hint_in[7:0];
                                n_scan  = 1'b0;
                                n_state = S_READ;
                            end else if (i_limit != 9'd0) begin
                                n_pg    = 8'd0;
                                n_scan  = 1'b1;
                                n_state = S_READ;
                            end else begin
                                n_out.status = ST_NO_SPACE;
                                n_out_valid  = 1'b1;
                            end
                        end
                        JOB_FREE: begin
                            n_pg    = i_job.page;
                            n_state = S_READ;
                        end
                        default: begin
                            n_out.status = i_job.status;
                            n_out_valid  = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (r_job.kind == JOB_FREE) begin
                    wr_en   = 1'b1;
                    wr_data = cur_map & ~(block_pattern(r_job.level) << r_job.blk);
                    if (r_hint[r_job.level] > {1'b0, r_pg}) begin
                        hint_en  = 1'b1;
                        hint_val = {1'b0, r_pg};
                    end
                    n_out        = '0;
                    n_out.status = ST_FREED;
                    n_out_valid  = 1'b1;
                end else if (freeb != 64'd0) begin
                    wr_en   = 1'b1;
                    wr_data = cur_map | (block_pattern(r_job.level) << idx);
                    if (!r_scan) begin
                        if (full || {1'b0, r_pg} != r_start) begin
                            hint_en  = 1'b1;
                            hint_val = full ? nxt_pg : {1'b0, r_pg};
                        end
                    end else if (!full && r_hint[r_job.level] > {1'b0, r_pg}) begin
                        hint_en  = 1'b1;
                        hint_val = {1'b0, r_pg};
                    end
                    n_out.alloc_offset   = {r_pg, idx, 10'd0} + 24'(HEADER_BYTES);
                    n_out.block_capacity = cap;
                    n_out.status         = ST_ALLOCATED;
                    n_out_valid          = 1'b1;
                end else if (nxt_pg < i_limit) begin
                    n_pg    = nxt_pg[7:0];
                    n_state = S_READ;
                end else if (!r_scan) begin
                    n_pg    = 8'd0;
                    n_scan  = 1'b1;
                    n_state = S_READ;
                end else begin
                    n_out        = '0;
                    n_out.status = ST_NO_SPACE;
                    n_out_valid  = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_pg    <= n_pg;
        r_scan  <= n_scan;
        r_start <= n_start;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_written   <= '0;
            for (int i = 0; i < LEVEL_COUNT; i++) r_hint[i] <= 9'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (wr_en) r_written[r_pg] <= 1'b1;
            if (hint_en) r_hint[r_job.level] <= hint_val;
        end
    end

endmodule

[rtl/core/paged_bitmap_buddy_allocator_top.sv]
// Top level of the paged bitmap buddy allocator: page count register and the
// front end, job queue and back end. Depends on pbba_pkg and the pbba_* modules.
//
// Usage. A request (allocate or free) is presented on i_request and taken at
// a rising edge where start is high and busy is low. Each request produces
// exactly one result, shown on o_result for a single cycle with
// o_result_valid high; the receiver must take it then, as it cannot stall.
// Results come out in request order.
// The page_count register is written through i_cfg_valid / i_cfg_data; the
// channel is always ready. Write it only while the block is idle.
// Timing. The front end classifies a request in the cycle it is taken and
// places it in a two-entry queue; busy rises when the queue is full.
// Rejected requests (too large, bad free) return in the cycle after the back end
// picks them up. A free reads, modifies and writes back the page map.
// An allocation reads pages one at a time; each page costs one map read and
// one evaluation in the back end, and the worst case reads every page in use
// twice.
// Reset. A synchronous active-low reset marks every page map as empty, clears
// the level hints, empties the queue and sets page_count to 256.
module paged_bitmap_buddy_allocator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pbba_pkg::t_request i_request,
    output logic              o_result_valid,
    output pbba_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [8:0]        i_cfg_data
);
    import pbba_pkg::*;

    logic [8:0] r_page_count;
    logic [8:0] limit;
    t_job       front_job, q_job;
    logic       q_full, q_valid, q_pop, push;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full;
    assign push        = start && !busy;

    // Scans never go past the physical page store.
    assign limit = (r_page_count < 9'(PAGES)) ? r_page_count : 9'(PAGES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= 9'd256;
        end else if (i_cfg_valid) begin
            r_page_count <= i_cfg_data;
        end
    end

    pbba_front u_front (
        .i_request (i_request),
        .o_job     (front_job)
    );

    pbba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    pbba_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_limit        (limit),
        .i_job_valid    (q_valid),
        .i_job          (q_job),
        .o_pop          (q_pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // A granted block always starts on a minimum-block boundary past the header.
    a_alloc_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status == ST_ALLOCATED) |->
        (o_result.alloc_offset[9:0] == 10'(HEADER_BYTES) && o_result.block_capacity != 17'd0))
        else $error("allocated result has a malformed offset or capacity");

    // Every other outcome carries no offset and no capacity.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status != ST_ALLOCATED) |->
        (o_result.alloc_offset == 24'd0 && o_result.block_capacity == 17'd0))
        else $error("non-allocation result carries an offset or capacity");

    // The queue only fills when the back end is holding an earlier request.
    a_busy_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> q_valid)
        else $error("busy raised with no request queued");

endmodule
